>>> sv/tvbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tvbe_pkg
// Types and tag constants shared by the tagged value byte encoder.
// ---------------------------------------------------------------------------
package tvbe_pkg;

    typedef enum logic [3:0] {
        FUNC_RAW     = 4'd0,
        FUNC_UINT    = 4'd1,
        FUNC_SINT    = 4'd2,
        FUNC_FLOAT   = 4'd3,
        FUNC_DOUBLE  = 4'd4,
        FUNC_OPCODE  = 4'd5,
        FUNC_CONST   = 4'd6,
        FUNC_DATA    = 4'd7,
        FUNC_STRING  = 4'd8,
        FUNC_SYMBOL  = 4'd9,
        FUNC_WIDESTR = 4'd10,
        FUNC_WIDENUM = 4'd11
    } t_func;

    localparam logic [7:0] TAG_UINT8   = 8'd0;
    localparam logic [7:0] TAG_UINT16  = 8'd64;
    localparam logic [7:0] TAG_UINT32  = 8'd128;
    localparam logic [7:0] TAG_SINT8   = 8'd8;
    localparam logic [7:0] TAG_SINT16  = 8'd72;
    localparam logic [7:0] TAG_SINT32  = 8'd136;
    localparam logic [7:0] TAG_FLOAT   = 8'd144;
    localparam logic [7:0] TAG_DOUBLE  = 8'd208;
    localparam logic [7:0] TAG_CONST   = 8'd24;
    localparam logic [7:0] TAG_DATA    = 8'd10;
    localparam logic [7:0] TAG_STRING  = 8'd50;
    localparam logic [7:0] TAG_SYMBOL  = 8'd42;
    localparam logic [7:0] TAG_WIDESTR = 8'd26;
    localparam logic [7:0] TAG_WIDENUM = 8'd34;
    localparam logic [3:0] OPCODE_LOW  = 4'd1;

    localparam int MAX_BYTES = 9;

    typedef struct packed {
        logic [3:0]  func;
        logic [63:0] value;
        logic [29:0] length;
        logic [7:0]  enc_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // encoded item: first byte in the top lane, count of bytes 1..9
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [3:0]             count;
    } t_desc;

endpackage
`default_nettype wire

>>> sv/tvbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tvbe_front
// Accepts requests, picks the encoding form and registers the byte image.
// ---------------------------------------------------------------------------
module tvbe_front import tvbe_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_desc         o_desc
);

    logic        r_valid;
    t_desc       r_desc;
    logic        n_valid;
    t_desc       n_desc;
    logic        w_known;
    logic [7:0]  w_b [MAX_BYTES];
    logic [3:0]  w_cnt;
    logic [30:0] w_len;
    logic [2:0]  w_groups;
    logic        w_take;

    assign o_stall = r_valid && i_stall;
    assign w_take  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_desc  = r_desc;

    // number of base-128 groups in the header length
    always_comb begin
        case (t_func'(i_data.func))
            FUNC_DATA:                  w_len = {1'b0, i_data.length} + 31'd1;
            FUNC_WIDESTR, FUNC_WIDENUM: w_len = {i_data.length, 1'b0};
            default:                    w_len = {1'b0, i_data.length};
        endcase
        w_groups = 3'd1 + 3'(w_len[30:7] != '0) + 3'(w_len[30:14] != '0)
                 + 3'(w_len[30:21] != '0) + 3'(w_len[30:28] != '0);
    end

    always_comb begin
        logic [31:0] w;
        logic [2:0]  k;
        logic [5:0]  shamt;
        logic [30:0] grp;
        w       = i_data.value[31:0];
        k       = '0;
        shamt   = '0;
        grp     = '0;
        w_known = 1'b1;
        w_cnt   = 4'd1;
        for (int j = 0; j < MAX_BYTES; j++) begin
            w_b[j] = '0;
        end
        case (i_data.func) inside
            FUNC_RAW: begin
                w_b[0] = i_data.value[7:0];
            end
            FUNC_UINT: begin
                if (w < 32'd256) begin
                    w_b[0] = TAG_UINT8;
                    w_b[1] = w[7:0];
                    w_cnt  = 4'd2;
                end else if (w < 32'd65536) begin
                    w_b[0] = TAG_UINT16;
                    w_b[1] = w[15:8];
                    w_b[2] = w[7:0];
                    w_cnt  = 4'd3;
                end else begin
                    w_b[0] = TAG_UINT32;
                    w_b[1] = w[31:24];
                    w_b[2] = w[23:16];
                    w_b[3] = w[15:8];
                    w_b[4] = w[7:0];
                    w_cnt  = 4'd5;
                end
            end
            FUNC_SINT: begin
                // magnitude test done as a signed range check
                if ($signed(w) >= -32'sd126 && $signed(w) <= 32'sd126) begin
                    w_b[0] = TAG_SINT8;
                    w_b[1] = w[7:0];
                    w_cnt  = 4'd2;
                end else if ($signed(w) >= -32'sd32766 && $signed(w) <= 32'sd32766) begin
                    w_b[0] = TAG_SINT16;
                    w_b[1] = w[15:8];
                    w_b[2] = w[7:0];
                    w_cnt  = 4'd3;
                end else begin
                    w_b[0] = TAG_SINT32;
                    w_b[1] = w[31:24];
                    w_b[2] = w[23:16];
                    w_b[3] = w[15:8];
                    w_b[4] = w[7:0];
                    w_cnt  = 4'd5;
                end
            end
            FUNC_FLOAT: begin
                w_b[0] = TAG_FLOAT;
                w_b[1] = w[31:24];
                w_b[2] = w[23:16];
                w_b[3] = w[15:8];
                w_b[4] = w[7:0];
                w_cnt  = 4'd5;
            end
            FUNC_DOUBLE: begin
                w_b[0] = TAG_DOUBLE;
                for (int j = 0; j < 8; j++) begin
                    w_b[j+1] = i_data.value[8*(7-j) +: 8];
                end
                w_cnt = 4'd9;
            end
            FUNC_OPCODE: begin
                w_b[0] = {w[3:0], OPCODE_LOW};
                w_b[1] = w[11:4];
                w_cnt  = 4'd2;
            end
            FUNC_CONST: begin
                w_b[0] = TAG_CONST;
                w_b[1] = i_data.value[7:0];
                w_cnt  = 4'd2;
            end
            [FUNC_DATA:FUNC_WIDENUM]: begin
                case (t_func'(i_data.func))
                    FUNC_DATA:    w_b[0] = TAG_DATA;
                    FUNC_STRING:  w_b[0] = TAG_STRING;
                    FUNC_SYMBOL:  w_b[0] = TAG_SYMBOL;
                    FUNC_WIDESTR: w_b[0] = TAG_WIDESTR;
                    default:      w_b[0] = TAG_WIDENUM;
                endcase
                for (int i = 0; i < 5; i++) begin
                    if (3'(i) < w_groups) begin
                        k        = w_groups - 3'(i) - 3'd1;
                        shamt    = 6'(k) * 6'd7;
                        grp      = w_len >> shamt;
                        w_b[i+1] = {k != 3'd0, grp[6:0]};
                    end
                end
                if (i_data.func == FUNC_DATA) begin
                    for (int j = 1; j < 7; j++) begin
                        if (3'(j) == w_groups + 3'd1) begin
                            w_b[j] = i_data.enc_byte;
                        end
                    end
                    w_cnt = {1'b0, w_groups} + 4'd2;
                end else begin
                    w_cnt = {1'b0, w_groups} + 4'd1;
                end
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid && i_stall;
        n_desc  = r_desc;
        if (w_take) begin
            n_valid = w_known;
            for (int j = 0; j < MAX_BYTES; j++) begin
                n_desc.bytes[8*(MAX_BYTES-1-j) +: 8] = w_b[j];
            end
            n_desc.count = w_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_desc <= n_desc;
    end

endmodule
`default_nettype wire

>>> sv/tvbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tvbe_queue
// Two-entry queue of encoded items between the front and back parts.
// ---------------------------------------------------------------------------
module tvbe_queue import tvbe_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_desc i_desc,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_desc      o_desc
);

    t_desc      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_desc  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule
`default_nettype wire

>>> sv/tvbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tvbe_back
// Shifts an encoded item out one byte per transfer, flagging the last byte.
// ---------------------------------------------------------------------------
module tvbe_back import tvbe_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_desc i_q_desc,
    output logic       o_q_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_out_item  o_data
);

    logic [8*MAX_BYTES-1:0] r_buf;
    logic [3:0]             r_cnt;
    logic [8*MAX_BYTES-1:0] n_buf;
    logic [3:0]             n_cnt;
    logic                   w_xfer;

    assign o_valid         = (r_cnt != 4'd0);
    assign o_data.out_byte = r_buf[8*MAX_BYTES-1 -: 8];
    assign o_data.last     = (r_cnt == 4'd1);
    assign w_xfer          = o_valid && !i_stall;
    // load the next item when the serializer is empty, or as the current last byte leaves
    assign o_q_pop = i_q_valid && ((r_cnt == 4'd0) || (r_cnt == 4'd1 && w_xfer));

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (o_q_pop) begin
            n_buf = i_q_desc.bytes;
            n_cnt = i_q_desc.count;
        end else if (w_xfer) begin
            n_buf = {r_buf[8*MAX_BYTES-9:0], 8'h00};
            n_cnt = r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_buf <= n_buf;
    end

endmodule
`default_nettype wire

>>> sv/tagged_value_byte_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// path: a request passes the front register, a queue entry and the serializer
// throughput: one output byte per cycle while i_stall is low; an item has
// 1 to 9 bytes, sent by the single-byte output serializer
// unused kind codes are accepted and produce no bytes
// reset is synchronous, active low, and empties front, queue and serializer
// ---------------------------------------------------------------------------
// tagged_value_byte_encoder_top
// Encodes value requests into tagged wire bytes, most significant first (opcodes low nibble first).
// ---------------------------------------------------------------------------
module tagged_value_byte_encoder_top import tvbe_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_data
);

    logic  f_valid;
    t_desc f_desc;
    logic  q_full;
    logic  q_valid;
    t_desc q_desc;
    logic  q_pop;

    tvbe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (f_valid),
        .i_stall (q_full),
        .o_desc  (f_desc)
    );

    tvbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (q_full),
        .i_desc  (f_desc),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_desc  (q_desc)
    );

    tvbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_desc),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    a_known_kind_reaches_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.func <= FUNC_WIDENUM) |=> f_valid)
        else $error("accepted request did not reach front register");

    a_full_queue_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> q_valid)
        else $error("queue full but not valid");

    a_stall_needs_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (f_valid && q_full))
        else $error("input stalled without back pressure");

    a_pop_only_with_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_valid)
        else $error("queue pop did not load serializer");

endmodule
`default_nettype wire

>>> tb/tb_tagged_value_byte_encoder_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tagged_value_byte_encoder_top
// Self-checking bench: requests go in from a queue, and every byte that comes
// out is checked against a local encoder model, under several mixes of
// sender gaps and receiver stalls, plus one long output hold-off.
// ---------------------------------------------------------------------------
module tb_tagged_value_byte_encoder_top;
    import tvbe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int TAIL_CYCLES    = 20;
    localparam int PRINT_LIMIT    = 50;

    // tag bytes, kept local so a wrong package constant cannot hide a bug
    localparam logic [7:0] ENC_U8      = 8'h00;
    localparam logic [7:0] ENC_U16     = 8'h40;
    localparam logic [7:0] ENC_U32     = 8'h80;
    localparam logic [7:0] ENC_S8      = 8'h08;
    localparam logic [7:0] ENC_S16     = 8'h48;
    localparam logic [7:0] ENC_S32     = 8'h88;
    localparam logic [7:0] ENC_FLOAT   = 8'h90;
    localparam logic [7:0] ENC_DOUBLE  = 8'hD0;
    localparam logic [7:0] ENC_CONST   = 8'h18;
    localparam logic [7:0] ENC_DATA    = 8'h0A;
    localparam logic [7:0] ENC_STRING  = 8'h32;
    localparam logic [7:0] ENC_SYMBOL  = 8'h2A;
    localparam logic [7:0] ENC_WIDESTR = 8'h1A;
    localparam logic [7:0] ENC_WIDENUM = 8'h22;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    t_in_item  pending_requests[$];
    t_out_item expected_bytes[$];

    int error_count    = 0;
    int queued_count   = 0;
    int accepted_count = 0;
    int idle_cycles    = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_trigger   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    tagged_value_byte_encoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic void push_byte(input logic [7:0] b);
        expected_bytes.push_back({b, 1'b0});
    endfunction

    function automatic void push_be(input logic [63:0] v, input int nbytes);
        for (int k = nbytes - 1; k >= 0; k--) begin
            push_byte(v[8*k +: 8]);
        end
    endfunction

    // big-endian base-128 groups, continuation bit on all but the final group
    function automatic void push_length(input logic [63:0] x);
        int          groups;
        logic [63:0] t;
        groups = 1;
        t = x >> 7;
        while (t != 64'd0) begin
            groups++;
            t = t >> 7;
        end
        for (int k = groups - 1; k >= 0; k--) begin
            t = x >> (7 * k);
            push_byte({k != 0, t[6:0]});
        end
    endfunction

    function automatic void encode_request(input t_in_item req);
        logic [31:0] w;
        logic [31:0] mag;
        int          first;
        t_out_item   tail;
        w = req.value[31:0];
        first = expected_bytes.size();
        case (req.func)
            FUNC_RAW: push_byte(req.value[7:0]);
            FUNC_UINT: begin
                if (w < 32'd256) begin
                    push_byte(ENC_U8);
                    push_be({32'd0, w}, 1);
                end else if (w < 32'd65536) begin
                    push_byte(ENC_U16);
                    push_be({32'd0, w}, 2);
                end else begin
                    push_byte(ENC_U32);
                    push_be({32'd0, w}, 4);
                end
            end
            FUNC_SINT: begin
                // most negative value wraps to 2^31, which lands in the long form
                mag = w[31] ? (~w + 32'd1) : w;
                if (mag < 32'd127) begin
                    push_byte(ENC_S8);
                    push_be({32'd0, w}, 1);
                end else if (mag < 32'd32767) begin
                    push_byte(ENC_S16);
                    push_be({32'd0, w}, 2);
                end else begin
                    push_byte(ENC_S32);
                    push_be({32'd0, w}, 4);
                end
            end
            FUNC_FLOAT: begin
                push_byte(ENC_FLOAT);
                push_be({32'd0, w}, 4);
            end
            FUNC_DOUBLE: begin
                push_byte(ENC_DOUBLE);
                push_be(req.value, 8);
            end
            FUNC_OPCODE: begin
                push_byte({w[3:0], 4'h1});
                push_byte(w[11:4]);
            end
            FUNC_CONST: begin
                push_byte(ENC_CONST);
                push_byte(req.value[7:0]);
            end
            FUNC_DATA: begin
                push_byte(ENC_DATA);
                push_length({34'd0, req.length} + 64'd1);
                push_byte(req.enc_byte);
            end
            FUNC_STRING: begin
                push_byte(ENC_STRING);
                push_length({34'd0, req.length});
            end
            FUNC_SYMBOL: begin
                push_byte(ENC_SYMBOL);
                push_length({34'd0, req.length});
            end
            FUNC_WIDESTR: begin
                push_byte(ENC_WIDESTR);
                push_length({33'd0, req.length, 1'b0});
            end
            FUNC_WIDENUM: begin
                push_byte(ENC_WIDENUM);
                push_length({33'd0, req.length, 1'b0});
            end
            default: ;
        endcase
        if (expected_bytes.size() > first) begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    task automatic queue_request(input logic [3:0] f, input logic [63:0] v,
                                 input logic [29:0] len);
        t_in_item req;
        req.func     = f;
        req.value    = v;
        req.length   = len;
        req.enc_byte = 8'($urandom);
        pending_requests.push_back(req);
        queued_count++;
    endtask

    task automatic queue_random(input int count);
        int          made;
        logic [3:0]  f;
        logic [63:0] v;
        logic [29:0] len;
        logic [31:0] r;
        made = 0;
        while (made < count) begin
            f = ($urandom_range(0, 99) < 5) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(0, 11));
            v = {$urandom, $urandom};
            r = $urandom;
            // bias the low word toward the size-class boundaries
            case ($urandom_range(0, 4))
                0: ;
                1: v[31:0] = $urandom_range(0, 70000);
                2: v[31:0] = {{24{r[7]}}, r[7:0]};
                3: v[31:0] = {{15{r[16]}}, r[16:0]};
                default: begin
                    case ($urandom_range(0, 9))
                        0: v[31:0] = 32'h0000_00FF;
                        1: v[31:0] = 32'h0000_0100;
                        2: v[31:0] = 32'h0000_FFFF;
                        3: v[31:0] = 32'h0001_0000;
                        4: v[31:0] = 32'h8000_0000;
                        5: v[31:0] = 32'h7FFF_FFFF;
                        6: v[31:0] = 32'hFFFF_FF81;
                        7: v[31:0] = 32'hFFFF_8001;
                        8: v[31:0] = 32'h0000_7FFE;
                        default: v[31:0] = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
            case ($urandom_range(0, 3))
                0: len = 30'($urandom_range(0, 130));
                1: len = 30'($urandom_range(0, 20000));
                2: begin
                    case ($urandom_range(0, 7))
                        0: len = 30'd127;
                        1: len = 30'd128;
                        2: len = 30'd16383;
                        3: len = 30'd16384;
                        4: len = 30'd2097151;
                        5: len = 30'd268435455;
                        6: len = 30'd268435456;
                        default: len = 30'h3FFF_FFFF;
                    endcase
                end
                default: len = 30'($urandom);
            endcase
            queue_request(f, v, len);
            if (f <= FUNC_WIDENUM) begin
                made++;
            end
        end
    endtask

    task automatic wait_drained;
        while (accepted_count != queued_count || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // request side
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            encode_request(i_data);
            accepted_count++;
        end
        if (!i_valid || !o_stall) begin
            if (i_rst_n && pending_requests.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct) begin
                i_data  <= pending_requests.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // byte side: random stalls, or a long hold-off when triggered
    always @(posedge i_clk) begin
        if (hold_seen != hold_trigger) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : byte_monitor
        t_out_item want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h with nothing pending", o_data.out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (o_data.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                              o_data.out_byte, want.out_byte));
                end
                if (o_data.last !== want.last) begin
                    report_mismatch($sformatf("last %b, wanted %b on byte %02h",
                                              o_data.last, want.last, want.out_byte));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size boundaries, every kind, ignored codes
        queue_request(FUNC_RAW,     64'hFFFF_FFFF_FFFF_FF5A, 30'h3FFF_FFFF);
        queue_request(FUNC_UINT,    64'h0,                   30'd0);
        queue_request(FUNC_UINT,    64'hFFFF_FFFF_0000_00FF, 30'd0);
        queue_request(FUNC_UINT,    64'h0000_0000_0000_0100, 30'd0);
        queue_request(FUNC_UINT,    64'h0000_0000_0000_FFFF, 30'd0);
        queue_request(FUNC_UINT,    64'h0000_0000_0001_0000, 30'd0);
        queue_request(FUNC_UINT,    64'h0000_0000_FFFF_FFFF, 30'd0);
        queue_request(FUNC_SINT,    64'h0000_0000_0000_007E, 30'd0);
        queue_request(FUNC_SINT,    64'h0000_0000_0000_007F, 30'd0);
        queue_request(FUNC_SINT,    64'h0000_0000_FFFF_FF82, 30'd0);
        queue_request(FUNC_SINT,    64'h0000_0000_FFFF_FF81, 30'd0);
        queue_request(FUNC_SINT,    64'h0000_0000_0000_7FFF, 30'd0);
        queue_request(FUNC_SINT,    64'h0000_0000_FFFF_8001, 30'd0);
        queue_request(FUNC_SINT,    64'hFFFF_FFFF_8000_0000, 30'd0);
        queue_request(FUNC_FLOAT,   64'h1234_5678_3F80_0000, 30'd0);
        queue_request(FUNC_DOUBLE,  64'h8000_0000_0000_0001, 30'd0);
        queue_request(FUNC_OPCODE,  64'hFFFF_FFFF_FFFF_FFFF, 30'd0);
        queue_request(FUNC_CONST,   64'h0000_0000_0000_01AB, 30'd0);
        queue_request(FUNC_DATA,    64'h0,                   30'd0);
        queue_request(FUNC_DATA,    64'h0,                   30'h3FFF_FFFF);
        queue_request(FUNC_STRING,  64'h0,                   30'd0);
        queue_request(FUNC_SYMBOL,  64'h0,                   30'd128);
        queue_request(FUNC_WIDESTR, 64'h0,                   30'd64);
        queue_request(FUNC_WIDENUM, 64'h0,                   30'h3FFF_FFFF);
        queue_request(4'd12,        64'hFFFF_FFFF_FFFF_FFFF, 30'd5);
        queue_request(4'd15,        64'h0,                   30'd0);
        wait_drained();

        queue_random(80);
        wait_drained();

        idle_pct <= 49;
        stall_pct <= 0;
        queue_random(80);
        wait_drained();

        idle_pct <= 0;
        stall_pct <= 49;
        queue_random(80);
        wait_drained();

        idle_pct <= 20;
        stall_pct <= 20;
        queue_random(80);
        wait_drained();

        // output held off while requests keep coming, so the input backs up
        idle_pct <= 0;
        stall_pct <= 0;
        hold_trigger <= hold_trigger + 1;
        queue_random(60);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
